// File: rtl/plid_pkg.sv
// ----------------------------------------------------------------------------
// plid_pkg
// Shared widths, request and status codes, and the cell control bundle for
// the positional list unit.
// ----------------------------------------------------------------------------
package plid_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int REQ_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;
    localparam int LEN_W_DEF = $clog2(CAPACITY_DEF + 1);

    // Request codes
    localparam logic [REQ_W-1:0] REQ_INS_HEAD = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INS_TAIL = 3'd1;
    localparam logic [REQ_W-1:0] REQ_INS_POS  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DEL_HEAD = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DEL_TAIL = 3'd4;
    localparam logic [REQ_W-1:0] REQ_DEL_POS  = 3'd5;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_DEL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

    // Broadcast to every cell: shift right to open a slot, or shift left to
    // close one.
    typedef struct packed {
        logic ins;
        logic del;
    } cell_ctl_t;

endpackage

// File: rtl/plid_req_if.sv
// ----------------------------------------------------------------------------
// plid_req_if
// Request channel: valid/ready handshake with the request payload.
// ----------------------------------------------------------------------------
interface plid_req_if;
    import plid_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [REQ_W-1:0]          req_type;
    logic signed [VALUE_W-1:0] value_in;
    logic [POS_W-1:0]          position;

    modport source (output valid, output req_type, output value_in, output position,
                    input ready);
    modport sink   (input valid, input req_type, input value_in, input position,
                    output ready);
endinterface

// File: rtl/plid_rsp_if.sv
// ----------------------------------------------------------------------------
// plid_rsp_if
// Response channel: valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
interface plid_rsp_if #(
    parameter int LEN_W = plid_pkg::LEN_W_DEF
);
    import plid_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic [LEN_W-1:0]          list_length;
    logic signed [VALUE_W-1:0] removed_value;

    modport source (output valid, output status, output list_length,
                    output removed_value, input ready);
    modport sink   (input valid, input status, input list_length,
                    input removed_value, output ready);
endinterface

// File: rtl/plid_cell.sv
// ----------------------------------------------------------------------------
// plid_cell
// One list slot: holds, takes its left neighbor, its right neighbor or the
// new value, depending on the broadcast operation and slot index.
// ----------------------------------------------------------------------------
module plid_cell #(
    parameter int IDX   = 0,
    parameter int IDX_W = 4
) (
    input  logic                               clk,
    input  plid_pkg::cell_ctl_t                ctl,
    input  logic [IDX_W-1:0]                   idx,
    input  logic signed [plid_pkg::VALUE_W-1:0] value,
    input  logic signed [plid_pkg::VALUE_W-1:0] left_data,
    input  logic signed [plid_pkg::VALUE_W-1:0] right_data,
    output logic signed [plid_pkg::VALUE_W-1:0] data
);
    import plid_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic signed [VALUE_W-1:0] data_reg;
    logic signed [VALUE_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.ins)
        begin
            if (MY_IDX > idx)
            begin
                data_next = left_data;
            end
            else if (MY_IDX == idx)
            begin
                data_next = value;
            end
        end
        else if (ctl.del)
        begin
            if (MY_IDX >= idx)
            begin
                data_next = right_data;
            end
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// File: rtl/positional_list_insert_delete_unit.sv
// ----------------------------------------------------------------------------
// positional_list_insert_delete_unit: the result is valid the cycle after the request.
// Throughput 1 request per cycle unless rsp stalls; every cell shifts together.
// Reset clears length and output valid; slot contents stay unknown until written.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_unit #(
    parameter int CAPACITY = plid_pkg::CAPACITY_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    plid_req_if.sink   req,
    plid_rsp_if.source rsp
);
    import plid_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // ------------------------------------------------------------------
    // Control state and output register
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      rsp_valid_reg;
    logic [STATUS_W-1:0]       status_reg;
    logic [STATUS_W-1:0]       status_next;
    logic [CNT_W-1:0]          len_reg;
    logic signed [VALUE_W-1:0] removed_reg;
    logic signed [VALUE_W-1:0] removed_next;

    logic       xfer_in;
    cell_ctl_t  ctl;
    logic [IDX_W-1:0] idx;

    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic             pos_gt_cnt;
    logic             pos_zero;
    logic             is_full;
    logic             is_empty;

    logic signed [VALUE_W-1:0] cell_data [CAPACITY];
    logic signed [VALUE_W-1:0] sel_data;

    // Accept a new request whenever the output register is free or drains now.
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign xfer_in   = req.valid && req.ready;

    assign pos_ext    = CMP_W'(req.position);
    assign cnt_ext    = CMP_W'(count_reg);
    assign pos_gt_cnt = pos_ext > cnt_ext;
    assign pos_zero   = (req.position == '0);
    assign is_full    = (count_reg == CAP_CNT);
    assign is_empty   = (count_reg == '0);

    // ------------------------------------------------------------------
    // Decode the request into one broadcast operation and a slot index.
    // Insert at a position: a position past the length lands at the tail;
    // position zero and the empty list both reduce to slot 0 this way.
    // ------------------------------------------------------------------
    always_comb
    begin
        ctl         = '0;
        idx         = '0;
        status_next = ST_DONE;
        count_next  = count_reg;
        case (req.req_type)
            REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_POS:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ctl.ins    = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (req.req_type == REQ_INS_TAIL)
                    begin
                        idx = count_reg[IDX_W-1:0];
                    end
                    else if (req.req_type == REQ_INS_POS)
                    begin
                        idx = pos_gt_cnt ? count_reg[IDX_W-1:0] : pos_ext[IDX_W-1:0];
                    end
                end
            end
            REQ_DEL_HEAD, REQ_DEL_TAIL:
            begin
                if (is_empty)
                begin
                    status_next = ST_NO_DEL;
                end
                else
                begin
                    ctl.del    = 1'b1;
                    count_next = count_reg - 1'b1;
                    if (req.req_type == REQ_DEL_TAIL)
                    begin
                        idx = count_reg[IDX_W-1:0] - 1'b1;
                    end
                end
            end
            REQ_DEL_POS:
            begin
                // 1-based numbering; position zero or past the length fails
                if (pos_zero || pos_gt_cnt)
                begin
                    status_next = ST_NO_DEL;
                end
                else
                begin
                    ctl.del    = 1'b1;
                    count_next = count_reg - 1'b1;
                    idx        = pos_ext[IDX_W-1:0] - 1'b1;
                end
            end
            default:
            begin
                // unused codes: no change, done
                status_next = ST_DONE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Chain of cells. Insert shifts every slot at or past idx one step
    // toward the tail; delete shifts every slot past idx one step toward
    // the head. Only a transferred request drives the shift.
    // ------------------------------------------------------------------
    cell_ctl_t cell_ctl;
    assign cell_ctl.ins = ctl.ins && xfer_in;
    assign cell_ctl.del = ctl.del && xfer_in;

    for (genvar gi = 0; gi < CAPACITY; gi++)
    begin : g_cell
        logic signed [VALUE_W-1:0] left_d;
        logic signed [VALUE_W-1:0] right_d;

        if (gi == 0)
        begin : g_first
            assign left_d = req.value_in;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[gi-1];
        end

        if (gi == CAPACITY - 1)
        begin : g_last
            assign right_d = cell_data[gi];
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[gi+1];
        end

        plid_cell #(
            .IDX   (gi),
            .IDX_W (IDX_W)
        ) u_cell (
            .clk        (clk),
            .ctl        (cell_ctl),
            .idx        (idx),
            .value      (req.value_in),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[gi])
        );
    end

    // Pick the slot a delete removes: one-hot AND-OR across the row.
    always_comb
    begin
        sel_data = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (IDX_W'(i) == idx)
            begin
                sel_data = sel_data | cell_data[i];
            end
        end
    end

    assign removed_next = ctl.del ? sel_data : '0;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (xfer_in)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: load on every request transfer, hold otherwise
    always_ff @(posedge clk)
    begin
        if (xfer_in)
        begin
            status_reg  <= status_next;
            len_reg     <= count_next;
            removed_reg <= removed_next;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.list_length   = len_reg;
    assign rsp.removed_value = removed_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("list length exceeds capacity");

    a_rsp_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        xfer_in |=> rsp_valid_reg && (len_reg == count_reg))
        else $error("result missing or length mismatch after request");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        xfer_in && (status_next == ST_FULL) |=> $stable(count_reg))
        else $error("refused insert changed the list");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !xfer_in |=> $stable(count_reg))
        else $error("length changed without a request");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the positional list unit. A shadow copy of the list
// predicts status, length and removed value for every request transfer and
// compares them in order against the result transfers. Both channels see
// random gaps, and one long receiver hold-off backs the unit up.
// ----------------------------------------------------------------------------
module tb_top;
    import plid_pkg::*;

    localparam int CAPACITY     = CAPACITY_DEF;
    localparam int LEN_W        = $clog2(CAPACITY + 1);
    localparam int RANDOM_ITEMS = 1032;
    localparam int PHASES       = 8;
    localparam int STALL_AT     = 400;     // result count that triggers the hold-off
    localparam int STALL_CYCLES = 150;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;

    // Request codes the unit must ignore
    localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic [LEN_W-1:0]          list_length;
        logic signed [VALUE_W-1:0] removed_value;
    } list_result_t;

    // ------------------------------------------------------------------------
    // Shadow list plus the queue of results still owed by the unit.
    // ------------------------------------------------------------------------
    class list_tracker;
        logic signed [VALUE_W-1:0] slots [CAPACITY];
        int unsigned               count;
        int unsigned               peak;
        list_result_t              pending_results [$];
        int unsigned               errors;
        int unsigned               checked;
        int unsigned               full_refusals;
        int unsigned               delete_refusals;
        int unsigned               removals;

        function new();
            count           = 0;
            peak            = 0;
            errors          = 0;
            checked         = 0;
            full_refusals   = 0;
            delete_refusals = 0;
            removals        = 0;
            foreach (slots[i]) slots[i] = '0;
        endfunction

        task report(input string what);
            errors++;
            $display("[%0t] MISMATCH: %s", $time, what);
        endtask

        function logic [STATUS_W-1:0] insert_at(input int unsigned idx,
                                                input logic signed [VALUE_W-1:0] val);
            int unsigned i;
            if (count >= CAPACITY)
                return ST_FULL;
            if (idx > count)
                idx = count;
            for (i = count; i > idx; i--)
                slots[i] = slots[i-1];
            slots[idx] = val;
            count++;
            if (count > peak)
                peak = count;
            return ST_DONE;
        endfunction

        function logic [STATUS_W-1:0] remove_at(input int unsigned idx,
                                                output logic signed [VALUE_W-1:0] gone);
            int unsigned i;
            gone = '0;
            if (count == 0 || idx >= count)
                return ST_NO_DEL;
            gone = slots[idx];
            for (i = idx; i + 1 < count; i++)
                slots[i] = slots[i+1];
            count--;
            return ST_DONE;
        endfunction

        function list_result_t predict_list_result(input logic [REQ_W-1:0] kind,
                                                   input logic signed [VALUE_W-1:0] val,
                                                   input logic [POS_W-1:0] pos);
            list_result_t              res;
            logic signed [VALUE_W-1:0] gone;
            res.status = ST_DONE;
            gone       = '0;
            case (kind)
                REQ_INS_HEAD: res.status = insert_at(0, val);
                REQ_INS_TAIL: res.status = insert_at(count, val);
                REQ_INS_POS:
                begin
                    if (pos == 0 || count == 0)
                        res.status = insert_at(0, val);
                    else
                        res.status = insert_at(pos, val);   // clamps to the tail
                end
                REQ_DEL_HEAD: res.status = remove_at(0, gone);
                REQ_DEL_TAIL:
                begin
                    if (count == 0)
                        res.status = ST_NO_DEL;
                    else
                        res.status = remove_at(count - 1, gone);
                end
                REQ_DEL_POS:
                begin
                    if (pos == 0 || pos > count)
                        res.status = ST_NO_DEL;
                    else
                        res.status = remove_at(pos - 1, gone);
                end
                default: ;   // spare codes leave the list alone
            endcase
            res.list_length   = count[LEN_W-1:0];
            res.removed_value = gone;
            return res;
        endfunction

        function void note_request(input logic [REQ_W-1:0] kind,
                                   input logic signed [VALUE_W-1:0] val,
                                   input logic [POS_W-1:0] pos);
            pending_results.push_back(predict_list_result(kind, val, pos));
        endfunction

        task check_result(input list_result_t got);
            list_result_t want;
            if (pending_results.size() == 0)
            begin
                report("result transfer with no request outstanding");
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (got.status !== want.status)
                report($sformatf("status got %0d want %0d", got.status, want.status));
            if (got.list_length !== want.list_length)
                report($sformatf("list_length got %0d want %0d",
                                 got.list_length, want.list_length));
            if (got.removed_value !== want.removed_value)
                report($sformatf("removed_value got %0d want %0d",
                                 got.removed_value, want.removed_value));
            case (want.status)
                ST_FULL:   full_refusals++;
                ST_NO_DEL: delete_refusals++;
                default:   if (want.removed_value != 0) removals++;
            endcase
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the unit under test
    // ------------------------------------------------------------------------
    logic clk;
    logic rst_n;

    plid_req_if req_ch ();
    plid_rsp_if #(.LEN_W(LEN_W)) rsp_ch ();

    positional_list_insert_delete_unit #(.CAPACITY(CAPACITY)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    list_tracker tracker = new();
    bit          gaps_on = 1'b1;     // cleared for back-to-back phases
    int unsigned sent_count = 0;
    int unsigned cycle_count = 0;

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gap length for either side: mostly none or short, a few long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Offer one request, hold it until the transfer, then idle for a gap.
    // Entered and left right after a rising edge.
    task automatic send_request(input logic [REQ_W-1:0] kind,
                                input logic signed [VALUE_W-1:0] val,
                                input logic [POS_W-1:0] pos);
        int unsigned gap;
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.value_in <= val;
        req_ch.position <= pos;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        tracker.note_request(kind, val, pos);
        sent_count++;
        gap = pick_gap();
        if (gap > 0)
        begin
            // Drop valid only when a gap follows; otherwise the next request
            // raises it in this same step and it must not toggle.
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Random mix in which ins_weight percent of requests are inserts. Positions sit
    // mostly around the current length so the in-range cases get exercised.
    task automatic run_random_phase(input int unsigned items, input int unsigned ins_weight);
        int unsigned               n;
        int unsigned               r;
        logic [REQ_W-1:0]          kind;
        logic signed [VALUE_W-1:0] val;
        logic [POS_W-1:0]          pos;
        for (n = 0; n < items; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                kind = r[0] ? REQ_SPARE_7 : REQ_SPARE_6;
            else if (r < 3 + ins_weight)
            begin
                case ($urandom_range(0, 2))
                    0:       kind = REQ_INS_HEAD;
                    1:       kind = REQ_INS_TAIL;
                    default: kind = REQ_INS_POS;
                endcase
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       kind = REQ_DEL_HEAD;
                    1:       kind = REQ_DEL_TAIL;
                    default: kind = REQ_DEL_POS;
                endcase
            end
            val = $urandom;
            if ($urandom_range(0, 9) < 3)
                pos = POS_W'($urandom_range(0, 255));
            else
                pos = POS_W'($urandom_range(0, tracker.count + 1));
            send_request(kind, val, pos);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: check each transfer, then pick the next ready level.
    // One long hold-off lets requests pile up and stall the request channel.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int unsigned  stall_left;
        int unsigned  seen;
        list_result_t got;
        stall_left = 0;
        seen       = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                got.status        = rsp_ch.status;
                got.list_length   = rsp_ch.list_length;
                got.removed_value = rsp_ch.removed_value;
                tracker.check_result(got);
                seen++;
                if (seen == STALL_AT)
                    stall_left = STALL_CYCLES;
            end
            if (stall_left == 0)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: count cycles and give up well past the slowest legal run.
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results outstanding",
                 cycle_count, tracker.pending_results.size());
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned ph;
        int unsigned weights [PHASES];

        weights = '{80, 20, 50, 90, 15, 50, 70, 30};

        // Hold every input at a known level from time zero.
        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= REQ_INS_HEAD;
        req_ch.value_in <= '0;
        req_ch.position <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Deletes on an empty list, in all three forms
        send_request(REQ_DEL_HEAD, 32'sd1, 8'd0);
        send_request(REQ_DEL_TAIL, 32'sd2, 8'd0);
        send_request(REQ_DEL_POS,  32'sd3, 8'd1);
        // Positional insert into an empty list lands at the head
        send_request(REQ_INS_POS,  32'sh7FFF_FFFF, 8'd7);
        // Tail delete of a one-element list empties it
        send_request(REQ_DEL_TAIL, 32'sd0, 8'd0);
        // Build up a short list using the field extremes
        send_request(REQ_INS_HEAD, 32'sh8000_0000, 8'd0);
        send_request(REQ_INS_TAIL, 32'sd0, 8'd255);
        send_request(REQ_INS_POS,  -32'sd1, 8'd0);          // position zero: head
        send_request(REQ_INS_POS,  32'sh5555_5555, 8'd255);  // beyond length: tail
        send_request(REQ_INS_POS,  32'shAAAA_AAAA, 8'd2);    // after element two
        // Positional deletes at zero and beyond the length are refused
        send_request(REQ_DEL_POS,  32'sd0, 8'd0);
        send_request(REQ_DEL_POS,  32'sd0, 8'd255);
        send_request(REQ_DEL_POS,  32'sd0, 8'd6);
        // Last element by position, first by position, then the head
        send_request(REQ_DEL_POS,  32'sd0, 8'd5);
        send_request(REQ_DEL_POS,  32'sd0, 8'd1);
        send_request(REQ_DEL_HEAD, 32'sd0, 8'd0);
        // Spare codes change nothing
        send_request(REQ_SPARE_6,  32'sh1234_5678, 8'd1);
        send_request(REQ_SPARE_7,  -32'sd42, 8'd170);

        // Random phases lean toward inserts (to fill past capacity) or deletes (to drain
        // to empty), with two even mixes; those two run back to back with no gaps at all.
        for (ph = 0; ph < PHASES; ph++)
        begin
            gaps_on = !(ph == 2 || ph == 5);
            run_random_phase(RANDOM_ITEMS / PHASES, weights[ph]);
        end
        gaps_on = 1'b1;
        req_ch.valid <= 1'b0;

        // Wait out the remaining results, then drain for stray transfers.
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d requests and %0d checked results in %0d cycles",
                 sent_count, tracker.checked, cycle_count);
        $display("Full refusals %0d, delete refusals %0d, values removed %0d, peak length %0d",
                 tracker.full_refusals, tracker.delete_refusals, tracker.removals,
                 tracker.peak);
        if (tracker.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
